// ===== rtl/http_request_framer_top_assert.svh =====
// Assertion macros for the request framer top level.
// Depends on signals named clk and rst in the including scope.
`ifndef HTTP_REQUEST_FRAMER_TOP_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_TOP_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define HRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define HRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/hrf_pkg.sv =====
// Shared types, codes, keyword constants and byte helpers for the request framer.
// No dependencies.
package hrf_pkg;

  typedef enum logic [6:0] {
    PH_REQ    = 7'b0000001,
    PH_HDR    = 7'b0000010,
    PH_BODY   = 7'b0000100,
    PH_CSIZE  = 7'b0001000,
    PH_CDATA  = 7'b0010000,
    PH_CTRAIL = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  localparam logic [2:0] EV_URI      = 3'd0;
  localparam logic [2:0] EV_ACCEPT   = 3'd1;
  localparam logic [2:0] EV_BODY     = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  localparam logic [1:0] METH_GET    = 2'd0;
  localparam logic [1:0] METH_POST   = 2'd1;
  localparam logic [1:0] METH_DELETE = 2'd2;

  localparam int F_GET     = 0;
  localparam int F_POST    = 1;
  localparam int F_DELETE  = 2;
  localparam int F_V10     = 3;
  localparam int F_V11     = 4;
  localparam int F_CLEN    = 5;
  localparam int F_TENC    = 6;
  localparam int F_CHUNKED = 7;

  localparam int STR_W = 136;
  localparam logic [STR_W-1:0] S_GET     = "GET";
  localparam logic [STR_W-1:0] S_POST    = "POST";
  localparam logic [STR_W-1:0] S_DELETE  = "DELETE";
  localparam logic [STR_W-1:0] S_V10     = "HTTP/1.0";
  localparam logic [STR_W-1:0] S_V11     = "HTTP/1.1";
  localparam logic [STR_W-1:0] S_CLEN    = "Content-Length";
  localparam logic [STR_W-1:0] S_TENC    = "Transfer-Encoding";
  localparam logic [STR_W-1:0] S_CHUNKED = "chunked";

  localparam logic [4:0] L_GET     = 5'd3;
  localparam logic [4:0] L_POST    = 5'd4;
  localparam logic [4:0] L_DELETE  = 5'd6;
  localparam logic [4:0] L_VER     = 5'd8;
  localparam logic [4:0] L_CLEN    = 5'd14;
  localparam logic [4:0] L_TENC    = 5'd17;
  localparam logic [4:0] L_CHUNKED = 5'd7;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Result queue depth; its pointers are three bits wide.
  localparam int RES_DEPTH = 8;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [1:0] method_code;
    logic       minor_version;
    logic       body_is_chunked;
  } result_t;

  typedef struct packed {
    logic item_valid;
    logic done;
  } stat_t;

  // True when byte b equals character pos of a keyword of length len.
  function automatic logic str_match(logic [STR_W-1:0] s, logic [4:0] len,
                                     logic [4:0] pos, logic [7:0] b);
    logic [4:0] idx;
    if (pos >= len) return 1'b0;
    idx = len - 5'd1 - pos;
    return s[{idx, 3'b000} +: 8] == b;
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_dec(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  // Returns {valid, value} for a hex digit.
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== rtl/hrf_parser.sv =====
// Byte parser: input register, per-byte state update and up to two results.
// Depends on hrf_pkg.
module hrf_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  logic [7:0]       in_byte,
  output logic [1:0]       push_n,
  output hrf_pkg::result_t res0,
  output hrf_pkg::result_t res1,
  output hrf_pkg::stat_t   stat
);

  localparam int AW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam logic [AW-1:0] LEN_MAX = AW'({LENGTH_BITS{1'b1}});

  typedef struct packed {
    hrf_pkg::phase_t        phase;
    logic                   cr;
    logic [1:0]             tok;
    logic                   intok;
    logic [4:0]             pos;
    logic [7:0]             flags;
    logic                   has;
    logic [AW-1:0]          acc;
    logic [LENGTH_BITS-1:0] dlen;
    logic                   chunked;
    logic [AW-1:0]          rem;
    logic [1:0]             skip;
  } st_t;

  typedef struct packed {
    st_t              s;
    logic [1:0]       n;
    hrf_pkg::result_t r0;
    hrf_pkg::result_t r1;
  } ctx_t;

  st_t        st;
  ctx_t       c_next;
  logic       item_valid;
  logic [7:0] item_byte;

  function automatic ctx_t emit(ctx_t c, logic [2:0] ev, logic [7:0] pay,
                                logic [1:0] meth, logic minor);
    hrf_pkg::result_t r;
    r.event_res       = ev;
    r.payload_byte    = pay;
    r.method_code     = meth;
    r.minor_version   = minor;
    r.body_is_chunked = c.s.chunked;
    if (c.n == 2'd0) begin
      c.r0 = r;
      c.n  = 2'd1;
    end else if (c.n == 2'd1) begin
      c.r1 = r;
      c.n  = 2'd2;
    end
    return c;
  endfunction

  function automatic ctx_t fail(ctx_t c);
    c = emit(c, hrf_pkg::EV_ERROR, 8'h00, 2'd0, 1'b0);
    c.s.phase = hrf_pkg::PH_DONE;
    return c;
  endfunction

  function automatic ctx_t new_line(ctx_t c);
    c.s.tok   = 2'd0;
    c.s.intok = 1'b0;
    c.s.pos   = 5'd0;
    c.s.flags = 8'hFF;
    c.s.has   = 1'b0;
    c.s.acc   = '0;
    return c;
  endfunction

  function automatic ctx_t adv(ctx_t c);
    if (c.s.pos != 5'd31) c.s.pos = c.s.pos + 5'd1;
    return c;
  endfunction

  function automatic ctx_t mchar(ctx_t c, int bit_i, logic [hrf_pkg::STR_W-1:0] s,
                                 logic [4:0] len, logic [7:0] b);
    if (!hrf_pkg::str_match(s, len, c.s.pos, b)) c.s.flags[bit_i] = 1'b0;
    return c;
  endfunction

  function automatic ctx_t mlen(ctx_t c, int bit_i, logic [4:0] len);
    if (c.s.pos != len) c.s.flags[bit_i] = 1'b0;
    return c;
  endfunction

  function automatic ctx_t end_req_token(ctx_t c);
    if (c.s.tok == 2'd0) begin
      c = mlen(c, hrf_pkg::F_GET, hrf_pkg::L_GET);
      c = mlen(c, hrf_pkg::F_POST, hrf_pkg::L_POST);
      c = mlen(c, hrf_pkg::F_DELETE, hrf_pkg::L_DELETE);
    end else if (c.s.tok == 2'd2) begin
      c = mlen(c, hrf_pkg::F_V10, hrf_pkg::L_VER);
      c = mlen(c, hrf_pkg::F_V11, hrf_pkg::L_VER);
    end
    if (c.s.tok != 2'd3) c.s.tok = c.s.tok + 2'd1;
    c.s.intok = 1'b0;
    return c;
  endfunction

  function automatic ctx_t req_byte(ctx_t c, logic [7:0] b);
    if (hrf_pkg::is_ws(b)) begin
      if (c.s.intok) c = end_req_token(c);
      return c;
    end
    if (!c.s.intok) begin
      c.s.intok = 1'b1;
      c.s.pos   = 5'd0;
    end
    if (c.s.tok == 2'd0) begin
      c = mchar(c, hrf_pkg::F_GET, hrf_pkg::S_GET, hrf_pkg::L_GET, b);
      c = mchar(c, hrf_pkg::F_POST, hrf_pkg::S_POST, hrf_pkg::L_POST, b);
      c = mchar(c, hrf_pkg::F_DELETE, hrf_pkg::S_DELETE, hrf_pkg::L_DELETE, b);
    end else if (c.s.tok == 2'd1) begin
      c = emit(c, hrf_pkg::EV_URI, b, 2'd0, 1'b0);
    end else if (c.s.tok == 2'd2) begin
      c = mchar(c, hrf_pkg::F_V10, hrf_pkg::S_V10, hrf_pkg::L_VER, b);
      c = mchar(c, hrf_pkg::F_V11, hrf_pkg::S_V11, hrf_pkg::L_VER, b);
    end
    c = adv(c);
    return c;
  endfunction

  function automatic ctx_t req_end(ctx_t c);
    logic [1:0] meth;
    if (c.s.intok) c = end_req_token(c);
    if (c.s.tok != 2'd3 ||
        !(c.s.flags[hrf_pkg::F_V10] || c.s.flags[hrf_pkg::F_V11]) ||
        !(c.s.flags[hrf_pkg::F_GET] || c.s.flags[hrf_pkg::F_POST] ||
          c.s.flags[hrf_pkg::F_DELETE])) begin
      return fail(c);
    end
    meth = c.s.flags[hrf_pkg::F_GET]  ? hrf_pkg::METH_GET :
           c.s.flags[hrf_pkg::F_POST] ? hrf_pkg::METH_POST : hrf_pkg::METH_DELETE;
    c = emit(c, hrf_pkg::EV_ACCEPT, 8'h00, meth, c.s.flags[hrf_pkg::F_V11]);
    c.s.phase = hrf_pkg::PH_HDR;
    c = new_line(c);
    return c;
  endfunction

  function automatic ctx_t hdr_byte(ctx_t c, logic [7:0] b);
    logic [AW+3:0] wide;
    c.s.has = 1'b1;
    if (c.s.tok == 2'd0) begin
      if (b == hrf_pkg::CH_COLON) begin
        c = mlen(c, hrf_pkg::F_CLEN, hrf_pkg::L_CLEN);
        c = mlen(c, hrf_pkg::F_TENC, hrf_pkg::L_TENC);
        c.s.tok = 2'd1;
        c.s.pos = 5'd0;
      end else begin
        c = mchar(c, hrf_pkg::F_CLEN, hrf_pkg::S_CLEN, hrf_pkg::L_CLEN, b);
        c = mchar(c, hrf_pkg::F_TENC, hrf_pkg::S_TENC, hrf_pkg::L_TENC, b);
        c = adv(c);
      end
      return c;
    end
    if (c.s.tok == 2'd1) begin
      if (hrf_pkg::is_ws(b)) return c;
      c.s.tok   = 2'd2;
      c.s.pos   = 5'd0;
      c.s.intok = 1'b1;
      c.s.acc   = '0;
    end
    if (c.s.tok == 2'd2) begin
      if (hrf_pkg::is_ws(b)) begin
        c = mlen(c, hrf_pkg::F_CHUNKED, hrf_pkg::L_CHUNKED);
        c.s.tok = 2'd3;
        return c;
      end
      c = mchar(c, hrf_pkg::F_CHUNKED, hrf_pkg::S_CHUNKED, hrf_pkg::L_CHUNKED, b);
      c = adv(c);
      if (c.s.intok) begin
        if (hrf_pkg::is_dec(b)) begin
          // acc * 10 + digit, saturating at the largest length.
          wide = {c.s.acc, 3'b000} + {2'b00, c.s.acc, 1'b0} +
                 (AW+4)'(b[3:0]);
          if (|wide[AW+3:LENGTH_BITS]) c.s.acc = LEN_MAX;
          else c.s.acc = wide[AW-1:0];
        end else begin
          c.s.intok = 1'b0;
        end
      end
    end
    return c;
  endfunction

  function automatic ctx_t hdr_end(ctx_t c);
    if (!c.s.has) begin
      if (c.s.chunked) begin
        c.s.phase = hrf_pkg::PH_CSIZE;
        c = new_line(c);
      end else if (c.s.dlen == '0) begin
        c = emit(c, hrf_pkg::EV_COMPLETE, 8'h00, 2'd0, 1'b0);
        c.s.phase = hrf_pkg::PH_DONE;
      end else begin
        c.s.rem   = AW'(c.s.dlen);
        c.s.phase = hrf_pkg::PH_BODY;
      end
      return c;
    end
    if (c.s.tok == 2'd2) c = mlen(c, hrf_pkg::F_CHUNKED, hrf_pkg::L_CHUNKED);
    if (c.s.tok != 2'd0) begin
      if (c.s.flags[hrf_pkg::F_CLEN]) c.s.dlen = c.s.acc[LENGTH_BITS-1:0];
      if (c.s.flags[hrf_pkg::F_TENC] && c.s.tok[1] && c.s.flags[hrf_pkg::F_CHUNKED])
        c.s.chunked = 1'b1;
    end
    c = new_line(c);
    return c;
  endfunction

  function automatic ctx_t csize_byte(ctx_t c, logic [7:0] b);
    logic [4:0] hv;
    c.s.has = 1'b1;
    hv = hrf_pkg::hex_val(b);
    if (!hv[4]) return fail(c);
    // Another digit overflows 32 bits once the top nibble is in use.
    if (c.s.acc[31:28] != 4'd0) return fail(c);
    c.s.acc = {c.s.acc[AW-5:0], hv[3:0]};
    return c;
  endfunction

  function automatic ctx_t csize_end(ctx_t c);
    if (!c.s.has) return fail(c);
    if (c.s.acc == '0) begin
      c = emit(c, hrf_pkg::EV_COMPLETE, 8'h00, 2'd0, 1'b0);
      c.s.phase = hrf_pkg::PH_DONE;
    end else begin
      c.s.rem   = c.s.acc;
      c.s.phase = hrf_pkg::PH_CDATA;
    end
    return c;
  endfunction

  function automatic ctx_t line_byte(ctx_t c, logic [7:0] b);
    if (c.s.phase == hrf_pkg::PH_REQ) return req_byte(c, b);
    if (c.s.phase == hrf_pkg::PH_HDR) return hdr_byte(c, b);
    return csize_byte(c, b);
  endfunction

  function automatic ctx_t line_end(ctx_t c);
    if (c.s.phase == hrf_pkg::PH_REQ) return req_end(c);
    if (c.s.phase == hrf_pkg::PH_HDR) return hdr_end(c);
    return csize_end(c);
  endfunction

  function automatic ctx_t step(st_t s, logic [7:0] b);
    ctx_t c;
    logic handled;
    c       = '0;
    c.s     = s;
    handled = 1'b0;
    case (s.phase)
      hrf_pkg::PH_REQ, hrf_pkg::PH_HDR, hrf_pkg::PH_CSIZE: begin
        if (c.s.cr) begin
          c.s.cr = 1'b0;
          if (b == hrf_pkg::CH_LF) begin
            c = line_end(c);
            handled = 1'b1;
          end else begin
            // A lone CR is an ordinary line byte.
            c = line_byte(c, hrf_pkg::CH_CR);
            if (c.s.phase != s.phase) handled = 1'b1;
          end
        end
        if (!handled) begin
          if (b == hrf_pkg::CH_CR) c.s.cr = 1'b1;
          else c = line_byte(c, b);
        end
      end
      hrf_pkg::PH_BODY: begin
        c = emit(c, hrf_pkg::EV_BODY, b, 2'd0, 1'b0);
        c.s.rem = c.s.rem - AW'(1);
        if (c.s.rem == '0) begin
          c = emit(c, hrf_pkg::EV_COMPLETE, 8'h00, 2'd0, 1'b0);
          c.s.phase = hrf_pkg::PH_DONE;
        end
      end
      hrf_pkg::PH_CDATA: begin
        c = emit(c, hrf_pkg::EV_BODY, b, 2'd0, 1'b0);
        c.s.rem = c.s.rem - AW'(1);
        if (c.s.rem == '0) begin
          c.s.skip  = 2'd2;
          c.s.phase = hrf_pkg::PH_CTRAIL;
        end
      end
      hrf_pkg::PH_CTRAIL: begin
        if (c.s.skip != 2'd0) c.s.skip = c.s.skip - 2'd1;
        if (c.s.skip == 2'd0) begin
          c.s.phase = hrf_pkg::PH_CSIZE;
          c.s.cr    = 1'b0;
          c = new_line(c);
        end
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_accept;
    end
    if (in_accept) item_byte <= in_byte;
  end

  always_comb begin
    c_next = step(st, item_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase   <= hrf_pkg::PH_REQ;
      st.cr      <= 1'b0;
      st.tok     <= 2'd0;
      st.intok   <= 1'b0;
      st.pos     <= 5'd0;
      st.flags   <= 8'hFF;
      st.has     <= 1'b0;
      st.acc     <= '0;
      st.dlen    <= '0;
      st.chunked <= 1'b0;
      st.rem     <= '0;
      st.skip    <= 2'd0;
    end else if (item_valid) begin
      st <= c_next.s;
    end
  end

  assign push_n          = item_valid ? c_next.n : 2'd0;
  assign res0            = c_next.r0;
  assign res1            = c_next.r1;
  assign stat.item_valid = item_valid;
  assign stat.done       = (st.phase == hrf_pkg::PH_DONE);

endmodule

// ===== rtl/hrf_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on hrf_pkg.
module hrf_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  hrf_pkg::result_t wr0,
  input  hrf_pkg::result_t wr1,
  input  logic             pop,
  output hrf_pkg::result_t rd,
  output logic             rd_valid,
  output logic [3:0]       level
);

  hrf_pkg::result_t mem [hrf_pkg::RES_DEPTH];
  logic [2:0] wp;
  logic [2:0] rp;
  logic       pop_ok;

  assign pop_ok   = pop && (level != 4'd0);
  assign rd       = mem[rp];
  assign rd_valid = (level != 4'd0);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp] <= wr0;
    if (push_n == 2'd2) mem[wp + 3'd1] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 3'd0;
      rp    <= 3'd0;
      level <= 4'd0;
    end else begin
      wp    <= wp + {1'b0, push_n};
      if (pop_ok) rp <= rp + 3'd1;
      level <= level + {2'b00, push_n} - {3'b000, pop_ok};
    end
  end

endmodule

// ===== rtl/http_request_framer_top.sv =====
// Top level of the HTTP request framer: stream ports, parser and result queue.
// Depends on hrf_pkg, hrf_parser, hrf_res_fifo and the assertion macro header.
//
//  Channel   Dir  Signals                        Carries
//  s_axis    in   tvalid tready tdata[7:0]       one request byte per transaction
//  m_axis    out  tvalid tready tdata[15:0]      one parse event per transaction
//
// Each accepted byte is held in an input register, the parser state is updated
// from it while it is held there, and its zero, one or two events enter an
// eight-entry result queue. Sustained rate is one byte per cycle; the only
// stall comes from the result queue, which stops taking bytes once it holds
// more than four events. An event passes through the input register and the
// result queue on its way to m_axis. Reset is synchronous and active high;
// after a complete or error event the block drops bytes until the next reset.
module http_request_framer_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [2:0] event_res, [10:3] payload_byte,
                                      // [12:11] method_code, [13] minor_version,
                                      // [14] body_is_chunked, [15] zero
);

  `include "http_request_framer_top_assert.svh"

  logic             in_accept;
  logic [1:0]       push_n;
  hrf_pkg::result_t res0;
  hrf_pkg::result_t res1;
  hrf_pkg::result_t rd;
  hrf_pkg::stat_t   stat;
  logic [3:0]       level;

  // The byte in the input register and the byte accepted now can each add two
  // events, so a new transaction is taken only with room for four.
  assign s_axis_tready = (level <= 4'(hrf_pkg::RES_DEPTH - 4));
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  hrf_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_byte   (s_axis_tdata),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .stat      (stat)
  );

  hrf_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .wr0      (res0),
    .wr1      (res1),
    .pop      (m_axis_tready),
    .rd       (rd),
    .rd_valid (m_axis_tvalid),
    .level    (level)
  );

  // Fields packed from the lowest bit up.
  assign m_axis_tdata = {1'b0, rd.body_is_chunked, rd.minor_version, rd.method_code,
                         rd.payload_byte, rd.event_res};

  // No events without a byte in the input register.
  `HRF_ASSERT_IMP(a_push_needs_item, !stat.item_valid, push_n == 2'd0, "push without item")
  // Once finished, the parser never produces another event.
  `HRF_ASSERT_IMP(a_done_silent, stat.done, push_n == 2'd0, "event after done")
  // A push always finds room in the queue.
  `HRF_ASSERT_IMP(a_push_room, push_n != 2'd0, level <= 4'(hrf_pkg::RES_DEPTH - 2),
                  "result queue overflow")
  // An empty queue with nothing pushed stays empty.
  `HRF_ASSERT_NXT(a_empty_hold, level == 4'd0 && push_n == 2'd0, level == 4'd0,
                  "queue level moved without push")

endmodule
